// ===== src/lesf_pkg.sv =====
// shared widths, limits and register indexes of the largest empty square finder
package lesf_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int SIZE_W = 11;
    localparam int LEN_W  = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH = 1'b0,
        REG_ROW_COUNT  = 1'b1
    } cfg_reg_t;

endpackage

// ===== src/lesf_cell_if.sv =====
// request channel carrying one map cell
interface lesf_cell_if;
    logic valid;
    logic ready;
    logic cell_free;

    modport source (output valid, output cell_free, input ready);
    modport sink (input valid, input cell_free, output ready);
endinterface

// ===== src/lesf_result_if.sv =====
// result channel carrying the largest square of one map
interface lesf_result_if;
    import lesf_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] best_size;
    logic [ROW_W-1:0]  best_row;
    logic [COL_W-1:0]  best_col;
    logic              found;

    modport source (
        output valid, output best_size, output best_row, output best_col, output found,
        input ready
    );
    modport sink (
        input valid, input best_size, input best_row, input best_col, input found,
        output ready
    );
endinterface

// ===== src/lesf_cfg_if.sv =====
// configuration write channel
interface lesf_cfg_if;
    import lesf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LEN_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/largest_empty_square_finder_unit.sv =====
// largest empty square finder: streaming maximal-square search with a line buffer
//
// Map cells are taken in raster order, one request per clock cycle with no gaps
// needed. Each cell is registered together with its row and column and a read
// of the line buffer (one simple-dual-port-style memory of MAX_COLS entries, one read
// and one write per cycle); the next cycle forms the min-of-three, increment and
// running maximum. The result of a map leaves through an output register, loaded
// when the map's last cell leaves the registered stage; a held result only stalls
// input once a further map's last cell reaches it. row_length and row_count
// take 0 as 1 and values above the limits as the limits. Configuration writes
// are accepted at any time and should be made while no map is in progress.
module largest_empty_square_finder_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    lesf_cfg_if.sink              cfg_chan,
    lesf_cell_if.sink             in_chan,
    lesf_result_if.source         out_chan
);
    import lesf_pkg::*;

    logic [LEN_W-1:0]  row_length_reg;
    logic [LEN_W-1:0]  row_count_reg;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  rows;

    logic [COL_W-1:0]  col_index_reg;
    logic [ROW_W-1:0]  row_index_reg;
    logic              last_col;
    logic              last_row;
    logic              in_acc;

    logic              s1_valid_reg;
    logic              s1_cell_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_last_col_reg;
    logic              s1_last_map_reg;
    logic              s1_fire;

    logic [SIZE_W-1:0] line_mem [MAX_COLS];
    logic [SIZE_W-1:0] rd_data_reg;
    logic              byp_reg;
    logic [SIZE_W-1:0] byp_data_reg;

    logic [SIZE_W-1:0] left_size_reg;
    logic [SIZE_W-1:0] diag_size_reg;
    logic [SIZE_W-1:0] max_size_reg;
    logic [ROW_W-1:0]  max_row_reg;
    logic [COL_W-1:0]  max_col_reg;

    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] diag;
    logic [SIZE_W-1:0] min_ul;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] cur;
    logic              better;
    logic [SIZE_W-1:0] max_size_next;
    logic [ROW_W-1:0]  max_row_next;
    logic [COL_W-1:0]  max_col_next;

    logic              out_valid_reg;

    // configuration
    assign cfg_chan.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_length_reg <= LEN_W'(MAX_COLS);
            row_count_reg  <= LEN_W'(MAX_ROWS);
        end else if (cfg_chan.valid) begin
            unique case (cfg_reg_t'(cfg_chan.index))
                REG_ROW_LENGTH: row_length_reg <= cfg_chan.data;
                REG_ROW_COUNT:  row_count_reg  <= cfg_chan.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (row_length_reg == '0) begin
            len = LEN_W'(1);
        end else if (row_length_reg > LEN_W'(MAX_COLS)) begin
            len = LEN_W'(MAX_COLS);
        end else begin
            len = row_length_reg;
        end
        if (row_count_reg == '0) begin
            rows = LEN_W'(1);
        end else if (row_count_reg > LEN_W'(MAX_ROWS)) begin
            rows = LEN_W'(MAX_ROWS);
        end else begin
            rows = row_count_reg;
        end
    end

    // raster position of the incoming cell
    assign last_col = (LEN_W'(col_index_reg) + LEN_W'(1)) >= len;
    assign last_row = (LEN_W'(row_index_reg) + LEN_W'(1)) >= rows;

    assign s1_fire       = s1_valid_reg && (!s1_last_map_reg || !out_valid_reg || out_chan.ready);
    assign in_chan.ready = !s1_valid_reg || s1_fire;
    assign in_acc        = in_chan.valid && in_chan.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_index_reg <= '0;
            row_index_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            if (in_acc) begin
                if (!last_col) begin
                    col_index_reg <= col_index_reg + COL_W'(1);
                end else if (!last_row) begin
                    col_index_reg <= '0;
                    row_index_reg <= row_index_reg + ROW_W'(1);
                end else begin
                    col_index_reg <= '0;
                    row_index_reg <= '0;
                end
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_acc) begin
            s1_cell_reg     <= in_chan.cell_free;
            s1_col_reg      <= col_index_reg;
            s1_row_reg      <= row_index_reg;
            s1_last_col_reg <= last_col;
            s1_last_map_reg <= last_col && last_row;
        end
    end

    // line buffer
    always_ff @(posedge clk) begin
        if (s1_fire) begin
            line_mem[s1_col_reg] <= cur;
        end
    end

    always_ff @(posedge clk) begin
        if (in_acc) begin
            rd_data_reg  <= line_mem[col_index_reg];
            byp_reg      <= s1_fire && (s1_col_reg == col_index_reg);
            byp_data_reg <= cur;
        end
    end

    // square size at the registered cell
    always_comb begin
        up   = '0;
        left = '0;
        diag = '0;
        if (s1_row_reg != '0) begin
            up = byp_reg ? byp_data_reg : rd_data_reg;
        end
        if (s1_col_reg != '0) begin
            left = left_size_reg;
            if (s1_row_reg != '0) begin
                diag = diag_size_reg;
            end
        end
        min_ul  = (left < up) ? left : up;
        min_all = (diag < min_ul) ? diag : min_ul;
        if (!s1_cell_reg) begin
            cur = '0;
        end else if (min_all == SIZE_SAT) begin
            cur = SIZE_SAT;
        end else begin
            cur = min_all + SIZE_W'(1);
        end
        better        = cur > max_size_reg;
        max_size_next = better ? cur : max_size_reg;
        max_row_next  = better ? s1_row_reg : max_row_reg;
        max_col_next  = better ? s1_col_reg : max_col_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            left_size_reg <= '0;
            diag_size_reg <= '0;
            max_size_reg  <= '0;
            max_row_reg   <= '0;
            max_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_fire) begin
                if (s1_last_col_reg) begin
                    left_size_reg <= '0;
                    diag_size_reg <= '0;
                end else begin
                    left_size_reg <= cur;
                    diag_size_reg <= up;
                end
                if (s1_last_map_reg) begin
                    max_size_reg <= '0;
                    max_row_reg  <= '0;
                    max_col_reg  <= '0;
                end else begin
                    max_size_reg <= max_size_next;
                    max_row_reg  <= max_row_next;
                    max_col_reg  <= max_col_next;
                end
            end
            if (s1_fire && s1_last_map_reg) begin
                out_valid_reg <= 1'b1;
            end else if (out_chan.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (s1_fire && s1_last_map_reg) begin
            out_chan.best_size <= max_size_next;
            out_chan.best_row  <= max_row_next;
            out_chan.best_col  <= max_col_next;
            out_chan.found     <= (max_size_next != '0);
        end
    end

    assign out_chan.valid = out_valid_reg;

endmodule
